/* rtl/prb_pkg.sv */
// ----------------------------------------------------------------------------
// prb_pkg: shared types and constants for the packet reorder buffer
// Table geometry, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package prb_pkg;

  // Table geometry
  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int SLOT_W    = $clog2(DEPTH + 1);
  localparam int ID_W      = 32;
  localparam int KIND_W    = 3;
  localparam int SLOT_IN_W = 4;

  // Drain releases at most this many entries per transaction
  localparam int DRAIN_MAX = 16;
  localparam int REL_W     = $clog2(DRAIN_MAX + 1);

  // Slot index that reports "none free" or "not found"
  localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(DEPTH);

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    K_INSERT     = 3'd0,
    K_FIND       = 3'd1,
    K_OLDEST     = 3'd2,
    K_NEXT_SEND  = 3'd3,
    K_UNMARK     = 3'd4,
    K_DRAIN      = 3'd5,
    K_CLEAR_SLOT = 3'd6,
    K_CLEAR_ALL  = 3'd7
  } kind_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_e;

endpackage

/* rtl/prb_if.sv */
// ----------------------------------------------------------------------------
// prb_in_if / prb_out_if: valid-ready channels of the packet reorder buffer
// Operation requests in, per-operation results out.
// ----------------------------------------------------------------------------
interface prb_in_if
  import prb_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [ID_W-1:0]      packet_id;
  logic [SLOT_IN_W-1:0] slot;
  logic                 mark_to_send;

  modport source (output valid, kind, packet_id, slot, mark_to_send, input ready);
  modport sink   (input valid, kind, packet_id, slot, mark_to_send, output ready);
endinterface

interface prb_out_if
  import prb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_index;
  logic [ID_W-1:0]   out_id;
  logic              found;
  logic              last;

  modport source (output valid, slot_index, out_id, found, last, input ready);
  modport sink   (input valid, slot_index, out_id, found, last, output ready);
endinterface

/* rtl/packet_reorder_buffer_unit.sv */
// ----------------------------------------------------------------------------
// packet_reorder_buffer_unit: slot table of packet IDs with valid/send marks
// One sequencer walks the slots with a single 32-bit compare unit to serve
// insert, find, oldest, next-to-send, unmark, drain and clear operations.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  in_i    | in  | valid / ready  | kind, packet_id, slot, mark_to_send
//  out_o   | out | valid / ready  | slot_index, out_id, found, last
//
//  Insert and find scan slots from 0 and stop at the first hit. Oldest and
//  next-to-send scan all DEPTH slots. Unmark and clear slot address their slot
//  directly; clear all empties the table. Drain rescans from slot 0 after each
//  released entry, plus one final scan. Each result goes through the result
//  stage. in_i.ready is high only between transactions; out_o.ready low stalls
//  the sequencer in its result stage. Reset empties the table at once.
// ----------------------------------------------------------------------------
module packet_reorder_buffer_unit
  import prb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  prb_in_if.sink    in_i,
  prb_out_if.source out_o
);

  // Sequencer and operation context
  state_e            state_q, state_d;
  kind_e             kind_q, kind_d;
  logic [ID_W-1:0]   key_q, key_d;
  logic              mark_q, mark_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SLOT_W-1:0] best_slot_q, best_slot_d;
  logic [REL_W-1:0]  rel_q, rel_d;

  // Drain lookahead: one released entry waits until its successor is known
  logic              hold_vld_q, hold_vld_d;
  logic [SLOT_W-1:0] hold_slot_q, hold_slot_d;
  logic [ID_W-1:0]   hold_id_q, hold_id_d;

  // Pending result
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  logic              res_found_q, res_found_d;
  logic              res_last_q, res_last_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [SLOT_W-1:0] out_slot_q;
  logic [ID_W-1:0]   out_id_q;
  logic              out_found_q;
  logic              out_last_q;
  logic              out_load;

  // Slot table
  logic [DEPTH-1:0]  valid_q, valid_d;
  logic [DEPTH-1:0]  pending_q, pending_d;
  logic [ID_W-1:0]   entry_id_q [DEPTH];
  logic              id_we;

  // Shared compare unit on the addressed entry
  logic [ID_W-1:0]   e_id;
  logic              e_valid, e_pend;
  logic              id_eq, id_lt;
  logic              at_end, elig, in_accept;

  assign e_id    = entry_id_q[idx_q];
  assign e_valid = valid_q[idx_q];
  assign e_pend  = pending_q[idx_q];
  assign id_eq   = (e_id == key_q);
  assign id_lt   = (e_id < key_q);
  assign at_end  = (idx_q == IDX_W'(DEPTH - 1));
  assign elig    = e_valid && ((kind_q != K_NEXT_SEND) || e_pend);

  assign in_i.ready = (state_q == S_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign out_load   = !out_valid_q || out_o.ready;

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    key_d       = key_q;
    mark_d      = mark_q;
    idx_d       = idx_q;
    best_slot_d = best_slot_q;
    rel_d       = rel_q;
    hold_vld_d  = hold_vld_q;
    hold_slot_d = hold_slot_q;
    hold_id_d   = hold_id_q;
    res_slot_d  = res_slot_q;
    res_id_d    = res_id_q;
    res_found_d = res_found_q;
    res_last_d  = res_last_q;
    valid_d     = valid_q;
    pending_d   = pending_q;
    id_we       = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          kind_d      = kind_e'(in_i.kind);
          key_d       = (kind_e'(in_i.kind) == K_DRAIN) ? in_i.packet_id + 1'b1
                                                        : in_i.packet_id;
          mark_d      = in_i.mark_to_send;
          idx_d       = '0;
          best_slot_d = SLOT_NONE;
          rel_d       = '0;
          hold_vld_d  = 1'b0;
          res_slot_d  = SLOT_NONE;
          res_id_d    = '0;
          res_found_d = 1'b0;
          res_last_d  = 1'b1;
          state_d     = S_SCAN;
          // Slot operations address one entry directly
          if (kind_e'(in_i.kind) inside {K_UNMARK, K_CLEAR_SLOT}) begin
            if (int'(in_i.slot) < DEPTH) begin
              idx_d = IDX_W'(in_i.slot);
            end else begin
              state_d = S_EMIT;
            end
          end
        end
      end

      S_SCAN: begin
        case (kind_q)
          K_INSERT: begin
            // Take the first free slot
            if (!e_valid) begin
              id_we              = 1'b1;
              valid_d[idx_q]     = 1'b1;
              pending_d[idx_q]   = mark_q;
              res_slot_d         = SLOT_W'(idx_q);
              res_id_d           = key_q;
              res_found_d        = 1'b1;
              state_d            = S_EMIT;
            end else if (at_end) begin
              state_d = S_EMIT;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end

          K_FIND: begin
            if (e_valid && id_eq) begin
              res_slot_d  = SLOT_W'(idx_q);
              res_id_d    = key_q;
              res_found_d = 1'b1;
              state_d     = S_EMIT;
            end else if (at_end) begin
              state_d = S_EMIT;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end

          K_OLDEST, K_NEXT_SEND: begin
            // Keep the smallest eligible ID; ties keep the lower slot
            if (elig && ((best_slot_q == SLOT_NONE) || id_lt)) begin
              best_slot_d = SLOT_W'(idx_q);
              key_d       = e_id;
            end
            if (at_end) begin
              res_slot_d  = best_slot_d;
              res_found_d = (best_slot_d != SLOT_NONE);
              res_id_d    = (best_slot_d != SLOT_NONE) ? key_d : '0;
              state_d     = S_EMIT;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end

          K_UNMARK, K_CLEAR_SLOT: begin
            res_slot_d       = SLOT_W'(idx_q);
            res_id_d         = e_valid ? e_id : '0;
            res_found_d      = e_valid;
            pending_d[idx_q] = 1'b0;
            if (kind_q == K_CLEAR_SLOT) begin
              valid_d[idx_q] = 1'b0;
            end
            state_d = S_EMIT;
          end

          K_DRAIN: begin
            if ((rel_q != REL_W'(DRAIN_MAX)) && e_valid && id_eq) begin
              // Release this entry; flush the held one as a non-final result
              valid_d[idx_q]   = 1'b0;
              pending_d[idx_q] = 1'b0;
              if (hold_vld_q) begin
                res_slot_d  = hold_slot_q;
                res_id_d    = hold_id_q;
                res_found_d = 1'b1;
                res_last_d  = 1'b0;
                state_d     = S_EMIT;
              end
              hold_vld_d  = 1'b1;
              hold_slot_d = SLOT_W'(idx_q);
              hold_id_d   = key_q;
              key_d       = key_q + 1'b1;
              rel_d       = rel_q + 1'b1;
              idx_d       = '0;
            end else if (at_end || (rel_q == REL_W'(DRAIN_MAX))) begin
              // Run ends: held entry becomes the final result
              res_last_d = 1'b1;
              if (hold_vld_q) begin
                res_slot_d  = hold_slot_q;
                res_id_d    = hold_id_q;
                res_found_d = 1'b1;
              end else begin
                res_slot_d  = SLOT_NONE;
                res_id_d    = '0;
                res_found_d = 1'b0;
              end
              hold_vld_d = 1'b0;
              state_d    = S_EMIT;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end

          K_CLEAR_ALL: begin
            valid_d   = '0;
            pending_d = '0;
            state_d   = S_EMIT;
          end

          default: begin
            state_d = S_EMIT;
          end
        endcase
      end

      S_EMIT: begin
        // Hand the result to the output register when it has room
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = res_last_q ? S_IDLE : S_SCAN;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      pending_q   <= '0;
      hold_vld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      valid_q     <= valid_d;
      pending_q   <= pending_d;
      hold_vld_q  <= hold_vld_d;
    end
  end

  // Operation context and result payload
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    key_q       <= key_d;
    mark_q      <= mark_d;
    idx_q       <= idx_d;
    best_slot_q <= best_slot_d;
    rel_q       <= rel_d;
    hold_slot_q <= hold_slot_d;
    hold_id_q   <= hold_id_d;
    res_slot_q  <= res_slot_d;
    res_id_q    <= res_id_d;
    res_found_q <= res_found_d;
    res_last_q  <= res_last_d;
    if ((state_q == S_EMIT) && out_load) begin
      out_slot_q  <= res_slot_q;
      out_id_q    <= res_id_q;
      out_found_q <= res_found_q;
      out_last_q  <= res_last_q;
    end
  end

  // ID storage: written only on insert
  always_ff @(posedge clk_i) begin
    if (id_we) begin
      entry_id_q[idx_q] <= key_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.slot_index = out_slot_q;
  assign out_o.out_id     = out_id_q;
  assign out_o.found      = out_found_q;
  assign out_o.last       = out_last_q;

  // A pending mark never outlives its entry
  a_pending_in_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q & ~valid_q) == '0)
    else $error("pending mark set on an empty slot");

  // No new transaction is taken right after one is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_i.ready)
    else $error("input accepted while an operation is in progress");

  // A successful insert reports a slot that now holds a valid entry
  a_insert_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && kind_q == K_INSERT && res_found_q)
      |-> valid_q[res_slot_q[IDX_W-1:0]])
    else $error("insert result points at an empty slot");

endmodule
